FILE: hw/rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants, register indexes and a saturating-increment helper function.
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int unsigned MAX_SETS_DEF   = 256;
   localparam int unsigned MAX_WAYS_DEF   = 8;
   localparam int unsigned ADDR_WIDTH_DEF = 48;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 4;
   localparam int unsigned CFG_W      = 4;
   localparam int unsigned TOTAL_W    = 32;

   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WAYS        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PREFETCH    = 2'd3;

   localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd2;
   localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd0;
   localparam logic [CFG_W-1:0] WAYS_RST        = 4'd1;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v,
                                                   input logic             en);
      sat_inc = (en && (v != '1)) ? v + 1'b1 : v;
   endfunction

endpackage

FILE: hw/rtl/salc_if.sv
// ----------------------------------------------------------------------------
// salc_if
// Valid/ready channel interfaces for requests, responses and CSR writes.
// ----------------------------------------------------------------------------
interface salc_req_if #(parameter int unsigned ADDR_WIDTH = 48);
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [ADDR_WIDTH-1:0] address;
   modport source (output valid, req_type, address, input ready);
   modport sink   (input valid, req_type, address, output ready);
endinterface

interface salc_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [1:0]  reads_added;
   logic        write_added;
   logic        prefetch_filled;
   logic [31:0] total_reads;
   logic [31:0] total_writes;
   logic [31:0] total_hits;
   logic [31:0] total_misses;
   modport source (output valid, hit, reads_added, write_added, prefetch_filled,
                   total_reads, total_writes, total_hits, total_misses,
                   input ready);
   modport sink   (input valid, hit, reads_added, write_added, prefetch_filled,
                   total_reads, total_writes, total_hits, total_misses,
                   output ready);
endinterface

interface salc_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [3:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/set_assoc_lru_cache_prefetch.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_prefetch
// Tag store of a set-associative LRU cache with next-line prefetch.
// ----------------------------------------------------------------------------
// One set is one memory row: MAX_WAYS tags followed by their MAX_WAYS valid
// bits. After reset the block walks every row once to clear it, and no
// request is accepted until every row is clear. An access reads its set,
// compares and writes the LRU-shifted row back, and moves the result into
// the output register; a miss with prefetch enabled adds a second
// read-modify-write pass on the next block's set before the result moves.
// One access is in flight at a time and the next can be accepted in the
// cycle after the result is loaded. A waiting result sits in its own
// register and only stalls the block when a second result is ready to be
// loaded. CSR writes are taken at any time and should be issued only while no
// access is in flight.
module set_assoc_lru_cache_prefetch #(
   parameter int unsigned MAX_SETS   = salc_pkg::MAX_SETS_DEF,
   parameter int unsigned MAX_WAYS   = salc_pkg::MAX_WAYS_DEF,
   parameter int unsigned ADDR_WIDTH = salc_pkg::ADDR_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   salc_req_if.sink   req,
   salc_rsp_if.source rsp,
   salc_csr_if.sink   csr
);
   import salc_pkg::*;

   localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int unsigned TAGS_W = ADDR_WIDTH * MAX_WAYS;
   localparam int unsigned ROW_W  = TAGS_W + MAX_WAYS;
   // largest n with 2^n <= MAX_SETS
   localparam int unsigned MAX_IB = $clog2(MAX_SETS + 1) - 1;
   localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_MOD, ST_PF_READ,
                             ST_PF_MOD, ST_RESP} state_type;

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      offset_bits_ff, index_bits_ff, ways_ff;
   logic                  prefetch_ff;
   logic                  is_write_ff;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [SET_W-1:0]      set_ff, set_in;
   logic [ADDR_WIDTH-1:0] tag_ff, tag_in;
   logic                  hit_ff, filled_ff;
   logic [TOTAL_W-1:0]    rd_tot_ff, wr_tot_ff, hit_tot_ff, miss_tot_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff, rsp_wr_ff, rsp_filled_ff;
   logic [1:0]            rsp_reads_ff;
   logic [TOTAL_W-1:0]    rsp_rd_tot_ff, rsp_wr_tot_ff, rsp_hit_tot_ff, rsp_miss_tot_ff;

   logic                  ram_we;
   logic [ROW_W-1:0]      ram_wdata, ram_rdata;
   logic [MAX_WAYS-1:0]   row_valid, new_valid;
   logic                  found;
   logic [WAY_W-1:0]      found_way, from_way;
   logic [CFG_W-1:0]      eff_ib;
   logic [WAY_W:0]        eff_w;
   logic [ADDR_WIDTH-1:0] nxt_addr;
   logic                  rsp_load;

   salc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (set_ff),
      .wr_data (ram_wdata),
      .rd_addr (set_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      eff_ib = (index_bits_ff > CFG_W'(MAX_IB)) ? CFG_W'(MAX_IB) : index_bits_ff;
      if (ways_ff == '0) eff_w = (WAY_W+1)'(1);
      else if (32'(ways_ff) > MAX_WAYS) eff_w = (WAY_W+1)'(MAX_WAYS);
      else eff_w = (WAY_W+1)'(ways_ff);
   end

   // split an address into set and tag under current geometry
   function automatic void split(input  logic [ADDR_WIDTH-1:0] a,
                                 input  logic [CFG_W-1:0]      ob,
                                 input  logic [CFG_W-1:0]      ib,
                                 output logic [SET_W-1:0]      s,
                                 output logic [ADDR_WIDTH-1:0] t);
      logic [ADDR_WIDTH-1:0] sh;
      logic [ADDR_WIDTH-1:0] m;
      sh = a >> ob;
      m  = ~({ADDR_WIDTH{1'b1}} << ib);
      s  = SET_W'(sh & m);
      if (MAX_SETS == 1) s = '0;
      t  = sh >> ib;
   endfunction

   always_comb begin
      row_valid = ram_rdata[TAGS_W +: MAX_WAYS];
      found     = 1'b0;
      found_way = '0;
      // highest matching way wins, as duplicates can survive a geometry change
      for (int i = 0; i < MAX_WAYS; i++) begin
         if ((i < 32'(eff_w)) && row_valid[i]
             && ram_rdata[i*ADDR_WIDTH +: ADDR_WIDTH] == tag_ff) begin
            found     = 1'b1;
            found_way = WAY_W'(i);
         end
      end
      from_way = found ? found_way : WAY_W'(eff_w - 1'b1);
      ram_wdata = ram_rdata;
      new_valid = row_valid;
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (i <= 32'(from_way)) begin
            ram_wdata[i*ADDR_WIDTH +: ADDR_WIDTH] =
               ram_rdata[(i-1)*ADDR_WIDTH +: ADDR_WIDTH];
            new_valid[i] = row_valid[i-1];
         end
      end
      ram_wdata[ADDR_WIDTH-1:0] = tag_ff;
      new_valid[0] = 1'b1;
      ram_wdata[TAGS_W +: MAX_WAYS] = new_valid;
      if (state_ff == ST_CLEAR) ram_wdata = '0;
      nxt_addr = addr_ff + (ADDR_WIDTH'(1) << offset_bits_ff);
   end

   assign ram_we = (state_ff == ST_CLEAR) || (state_ff == ST_MOD)
                   || (state_ff == ST_PF_MOD && !found);
   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      set_in   = set_ff;
      tag_in   = tag_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            set_in = set_ff + 1'b1;
            if (set_ff == LAST_SET) state_in = ST_IDLE;
         end
         ST_IDLE:    if (req.valid && req.ready) state_in = ST_READ;
         ST_READ:    state_in = ST_MOD;
         ST_MOD: begin
            if (!found && prefetch_ff) begin
               split(nxt_addr, offset_bits_ff, eff_ib, set_in, tag_in);
               state_in = ST_PF_READ;
            end else state_in = ST_RESP;
         end
         ST_PF_READ: state_in = ST_PF_MOD;
         ST_PF_MOD:  state_in = ST_RESP;
         ST_RESP:    if (rsp_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
      if (state_ff == ST_IDLE) begin
         addr_in = req.address;
         split(req.address, offset_bits_ff, eff_ib, set_in, tag_in);
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      tag_ff  <= tag_in;
      if (req.valid && req.ready) is_write_ff <= req.req_type;
      if (rsp_load) begin
         rsp_hit_ff      <= hit_ff;
         rsp_reads_ff    <= hit_ff ? 2'd0 : (filled_ff ? 2'd2 : 2'd1);
         rsp_wr_ff       <= is_write_ff;
         rsp_filled_ff   <= filled_ff;
         rsp_rd_tot_ff   <= rd_tot_ff;
         rsp_wr_tot_ff   <= wr_tot_ff;
         rsp_hit_tot_ff  <= hit_tot_ff;
         rsp_miss_tot_ff <= miss_tot_ff;
      end
      if (reset) begin
         state_ff       <= ST_CLEAR;
         set_ff         <= '0;
         offset_bits_ff <= OFFSET_BITS_RST;
         index_bits_ff  <= INDEX_BITS_RST;
         ways_ff        <= WAYS_RST;
         prefetch_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hit_ff         <= 1'b0;
         filled_ff      <= 1'b0;
         rd_tot_ff      <= '0;
         wr_tot_ff      <= '0;
         hit_tot_ff     <= '0;
         miss_tot_ff    <= '0;
      end else begin
         state_ff <= state_in;
         set_ff   <= set_in;
         if (csr.valid) begin
            unique case (csr.index)
               REG_OFFSET_BITS: offset_bits_ff <= csr.data;
               REG_INDEX_BITS:  index_bits_ff  <= csr.data;
               REG_WAYS:        ways_ff        <= csr.data;
               REG_PREFETCH:    prefetch_ff    <= csr.data[0];
               default: ;
            endcase
         end
         if (state_ff == ST_MOD) begin
            hit_ff      <= found;
            filled_ff   <= 1'b0;
            hit_tot_ff  <= sat_inc(hit_tot_ff, found);
            miss_tot_ff <= sat_inc(miss_tot_ff, !found);
            rd_tot_ff   <= sat_inc(rd_tot_ff, !found);
            wr_tot_ff   <= sat_inc(wr_tot_ff, is_write_ff == REQ_WRITE);
         end
         if (state_ff == ST_PF_MOD) begin
            filled_ff <= !found;
            rd_tot_ff <= sat_inc(rd_tot_ff, !found);
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.hit             = rsp_hit_ff;
   assign rsp.reads_added     = rsp_reads_ff;
   assign rsp.write_added     = rsp_wr_ff;
   assign rsp.prefetch_filled = rsp_filled_ff;
   assign rsp.total_reads     = rsp_rd_tot_ff;
   assign rsp.total_writes    = rsp_wr_tot_ff;
   assign rsp.total_hits      = rsp_hit_tot_ff;
   assign rsp.total_misses    = rsp_miss_tot_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> (state_ff == ST_IDLE)) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.total_reads)
                                     && $stable(rsp.write_added)))
      else $error("response changed while stalled");
   a_fill_miss: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.hit && rsp.prefetch_filled)) else $error("fill on hit");
   a_we_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_MOD || state_ff == ST_PF_MOD))
      else $error("stray write");
endmodule

FILE: verif/set_assoc_lru_cache_prefetch_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_prefetch_tb
// Drives random and directed cache accesses through the block, and checks
// every response against a behavioural LRU tag-store model kept here.
// ----------------------------------------------------------------------------

class lru_scoreboard;
   logic [47:0] tags  [256][8];
   bit          vbits [256][8];
   logic [31:0] n_reads, n_writes, n_hits, n_misses;
   logic [3:0]  off_bits, idx_bits, ways_cfg;
   bit          pf_en;
   logic [1:0]  exp_reads_q [$];
   bit          exp_hit_q [$], exp_wr_q [$], exp_pf_q [$];
   logic [31:0] exp_tr_q [$], exp_tw_q [$], exp_th_q [$], exp_tm_q [$];
   int          errors;

   function void init();
      foreach (vbits[s, w]) begin
         vbits[s][w] = 0;
         tags[s][w] = '0;
      end
      n_reads = 0; n_writes = 0; n_hits = 0; n_misses = 0;
      off_bits = salc_pkg::OFFSET_BITS_RST;
      idx_bits = salc_pkg::INDEX_BITS_RST;
      ways_cfg = salc_pkg::WAYS_RST;
      pf_en = 0;
      errors = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
         salc_pkg::REG_OFFSET_BITS: off_bits = val;
         salc_pkg::REG_INDEX_BITS:  idx_bits = val;
         salc_pkg::REG_WAYS:        ways_cfg = val;
         salc_pkg::REG_PREFETCH:    pf_en = val[0];
      endcase
   endfunction

   function int n_ways();
      if (ways_cfg == 0) return 1;
      if (ways_cfg > 8) return 8;
      return ways_cfg;
   endfunction

   function void split(logic [47:0] a, output int set, output logic [47:0] tag);
      int ib;
      int sh;
      ib = (idx_bits > 8) ? 8 : idx_bits;
      sh = off_bits + ib;
      set = int'((a >> off_bits) & ((48'd1 << ib) - 1));
      tag = (sh >= 48) ? '0 : (a >> sh);
   endfunction

   function int find_way(int set, logic [47:0] tag);
      for (int i = n_ways() - 1; i >= 0; i--)
         if (vbits[set][i] && tags[set][i] == tag) return i;
      return -1;
   endfunction

   function void promote(int set, int from, logic [47:0] tag);
      for (int i = from; i > 0; i--) begin
         tags[set][i] = tags[set][i-1];
         vbits[set][i] = vbits[set][i-1];
      end
      tags[set][0] = tag;
      vbits[set][0] = 1;
   endfunction

   function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 1;
   endfunction

   function void note_access(bit is_wr, logic [47:0] a);
      int set, way;
      logic [47:0] tag, nxt;
      bit hit, filled;
      logic [1:0] rd;
      hit = 0; filled = 0; rd = 0;
      split(a, set, tag);
      way = find_way(set, tag);
      if (way >= 0) begin
         hit = 1;
         n_hits = bump(n_hits);
         promote(set, way, tag);
      end else begin
         rd = 1;
         n_misses = bump(n_misses);
         n_reads = bump(n_reads);
         promote(set, n_ways() - 1, tag);
         if (pf_en) begin
            nxt = a + (48'd1 << off_bits);
            split(nxt, set, tag);
            if (find_way(set, tag) < 0) begin
               rd = 2;
               filled = 1;
               n_reads = bump(n_reads);
               promote(set, n_ways() - 1, tag);
            end
         end
      end
      if (is_wr) n_writes = bump(n_writes);
      exp_hit_q.push_back(hit); exp_reads_q.push_back(rd);
      exp_wr_q.push_back(is_wr); exp_pf_q.push_back(filled);
      exp_tr_q.push_back(n_reads); exp_tw_q.push_back(n_writes);
      exp_th_q.push_back(n_hits); exp_tm_q.push_back(n_misses);
   endfunction

   function void cmp(string f, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, f, e, a);
      end
   endfunction

   function void check_rsp(bit hit, logic [1:0] rd, bit wr, bit pf,
                           logic [31:0] tr, tw, th, tm);
      if (exp_hit_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected response, expected none actual hit=%0b", $time, hit);
         return;
      end
      cmp("hit", exp_hit_q.pop_front(), hit);
      cmp("reads_added", exp_reads_q.pop_front(), rd);
      cmp("write_added", exp_wr_q.pop_front(), wr);
      cmp("prefetch_filled", exp_pf_q.pop_front(), pf);
      cmp("total_reads", exp_tr_q.pop_front(), tr);
      cmp("total_writes", exp_tw_q.pop_front(), tw);
      cmp("total_hits", exp_th_q.pop_front(), th);
      cmp("total_misses", exp_tm_q.pop_front(), tm);
   endfunction

   function int pending();
      return exp_hit_q.size();
   endfunction
endclass

module set_assoc_lru_cache_prefetch_tb;
   import salc_pkg::*;

   logic clock, reset;
   salc_req_if #(.ADDR_WIDTH(48)) req();
   salc_rsp_if rsp();
   salc_csr_if csr();

   set_assoc_lru_cache_prefetch DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   lru_scoreboard tags_sb;
   int  src_idle_pct, sink_stall_pct;
   int  quiet_cycles;
   logic [47:0] recent_addr [8];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // response side: ready changes on the falling edge, sampling on the rising
   always @(negedge clock) begin
      if (reset) rsp.ready <= 0;
      else rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         tags_sb.check_rsp(rsp.hit, rsp.reads_added, rsp.write_added, rsp.prefetch_filled,
                           rsp.total_reads, rsp.total_writes, rsp.total_hits,
                           rsp.total_misses);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("set_assoc_lru_cache_prefetch: mismatch");
            $finish;
         end
      end
   end

   // valid is left high on return; set_geometry drops it after the last write
   task automatic write_csr(logic [1:0] idx, logic [3:0] val);
      csr.valid <= 1; csr.index <= idx; csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      tags_sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   // valid is left high on return; drain() or an idle gap before the next transaction drops it
   task automatic send_access(bit is_wr, logic [47:0] a);
      while ($urandom_range(99) < src_idle_pct) begin
         req.valid <= 0;
         @(negedge clock);
      end
      req.valid <= 1; req.req_type <= is_wr; req.address <= a;
      do @(posedge clock); while (!req.ready);
      tags_sb.note_access(is_wr, a);
      recent_addr[$urandom_range(7)] = a;
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (tags_sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_geometry(logic [3:0] ob, logic [3:0] ib, logic [3:0] w, bit pf);
      drain();
      write_csr(REG_OFFSET_BITS, ob);
      write_csr(REG_INDEX_BITS, ib);
      write_csr(REG_WAYS, w);
      write_csr(REG_PREFETCH, {3'b0, pf});
      csr.valid <= 0;
   endtask

   // mostly addresses near recently used ones so hits and evictions occur
   task automatic random_burst(int n);
      logic [47:0] a;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: a = 48'({$urandom, $urandom});
            1: a = recent_addr[$urandom_range(7)];
            default: a = recent_addr[$urandom_range(7)]
                         ^ (48'd1 << $urandom_range(tags_sb.off_bits + 10));
         endcase
         send_access(1'($urandom_range(1)), a);
      end
   endtask

   initial begin
      tags_sb = new();
      tags_sb.init();
      src_idle_pct = 0; sink_stall_pct = 0;
      req.valid = 0; req.req_type = 0; req.address = '0;
      csr.valid = 0; csr.index = '0; csr.data = '0;
      foreach (recent_addr[i]) recent_addr[i] = '0;
      reset = 1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset geometry, extremes of address, repeat hits, writes
      send_access(REQ_READ, 48'h0);
      send_access(REQ_READ, 48'h0);
      send_access(REQ_WRITE, 48'hFFFF_FFFF_FFFF);
      send_access(REQ_WRITE, 48'hFFFF_FFFF_FFFF);
      send_access(REQ_READ, 48'hAAAA_5555_AAAA);
      // prefetch with wrap of the next block past the top of the address space
      set_geometry(4'd4, 4'd2, 4'd2, 1);
      send_access(REQ_READ, 48'hFFFF_FFFF_FFF0);
      send_access(REQ_READ, 48'h0);
      send_access(REQ_WRITE, 48'h0000_0000_0010);
      send_access(REQ_READ, 48'h0000_0000_0020);
      send_access(REQ_READ, 48'h0000_0000_0010);
      // out-of-range settings: zero ways, too many ways, too many sets
      set_geometry(4'd0, 4'd15, 4'd0, 1);
      send_access(REQ_READ, 48'h1234);
      send_access(REQ_READ, 48'h1234);
      send_access(REQ_WRITE, 48'h1334);
      set_geometry(4'd12, 4'd8, 4'd15, 0);
      send_access(REQ_READ, 48'h5555_5555_5555);
      send_access(REQ_READ, 48'h5555_5555_5555);
      // geometry change with no flush
      set_geometry(4'd15, 4'd9, 4'd8, 1);
      send_access(REQ_READ, 48'h5555_5555_5555);
      send_access(REQ_WRITE, 48'h8000_0000_0000);
      // fully associative, eviction order
      set_geometry(4'd2, 4'd0, 4'd4, 0);
      for (int i = 0; i < 6; i++) send_access(REQ_READ, 48'(i * 4));
      send_access(REQ_READ, 48'h0);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
            3: begin src_idle_pct = 37; sink_stall_pct = 37; end
         endcase
         case (ph)
            0: set_geometry(4'd2, 4'd0, 4'd1, 0);
            1: set_geometry(4'd6, 4'd3, 4'd8, 1);
            7: set_geometry(4'd12, 4'd8, 4'd8, 1);
            default: set_geometry(4'($urandom_range(8)), 4'($urandom_range(4)),
                                  4'($urandom_range(1, 8)), 1'($urandom_range(1)));
         endcase
         random_burst(40);
         drain();  // sender holds off until all responses are back
         random_burst(40);
      end

      drain();
      repeat (20) @(negedge clock);
      if (tags_sb.errors == 0)
         $display("set_assoc_lru_cache_prefetch: match");
      else
         $display("set_assoc_lru_cache_prefetch: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/salc_pkg.sv
hw/rtl/salc_if.sv
hw/rtl/salc_ram.sv
hw/rtl/set_assoc_lru_cache_prefetch.sv
verif/set_assoc_lru_cache_prefetch_tb.sv
